// ----- hdl/sse_pkg.sv -----
// Shared types and constants for the sorted-sample entropy block.
// No dependencies; used by sse_ctrl, sse_dp, sorted_sample_entropy and sse_checker.
package sse_pkg;

  localparam int unsigned SumWidth = 40;
  localparam int unsigned OutWidth = 21;
  localparam int unsigned StWidth  = 2;

  localparam logic [StWidth-1:0] StOk        = 2'd0;
  localparam logic [StWidth-1:0] StNotSorted = 2'd1;
  localparam logic [StWidth-1:0] StTooMany   = 2'd2;

  // Controller to datapath.
  typedef struct packed {
    logic take;       // register the incoming sample and update counters
    logic log_start;  // load the log2 unit with the selected operand
    logic log_sel_n;  // 0: run length, 1: sample count
    logic log_step;   // one square-and-compare step
    logic acc_run;    // add c*log2(c) to the sum
    logic div_start;  // begin S / N
    logic div_step;   // one restoring division step
    logic finish;     // form the result
    logic clear;      // return to reset state
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic close_run;  // the taken sample ended a run
    logic last;       // the taken sample carried the final mark
    logic final_ok;   // no error and at least one sample
    logic run_nz;     // open run length nonzero
  } sts_t;

endpackage

// ----- hdl/sse_ctrl.sv -----
// Sequencer for the entropy block: takes requests, steps log2 and divider.
// Depends on sse_pkg.
module sse_ctrl #(
  parameter int unsigned FracBits = 16,
  parameter int unsigned DivSteps = 17
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output sse_pkg::cmd_t cmd_o,
  input  sse_pkg::sts_t sts_i
);

  typedef enum logic [2:0] {
    SIdle, SDecide, SRunLog, SRunAcc, SFinLog, SDiv, SOut
  } state_e;

  localparam int unsigned CntW = $clog2((FracBits > DivSteps ? FracBits : DivSteps) + 1);

  state_e state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    out_valid_d = out_valid_q;
    cmd_o = '0;
    unique case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d = SDecide;
        end
      end
      SDecide: begin
        if (sts_i.close_run) begin
          cmd_o.log_start = 1'b1;
          cnt_d = CntW'(FracBits);
          state_d = SRunLog;
        end else if (sts_i.last) begin
          if (sts_i.final_ok && sts_i.run_nz) begin
            cmd_o.log_start = 1'b1;
            cnt_d = CntW'(FracBits);
            state_d = SRunLog;
          end else begin
            cmd_o.finish = 1'b1;
            out_valid_d = 1'b1;
            state_d = SOut;
          end
        end else begin
          state_d = SIdle;
        end
      end
      SRunLog: begin
        cmd_o.log_step = 1'b1;
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) state_d = SRunAcc;
      end
      SRunAcc: begin
        cmd_o.acc_run = 1'b1;
        if (sts_i.last && sts_i.final_ok) begin
          cmd_o.log_start = 1'b1;
          cmd_o.log_sel_n = 1'b1;
          cmd_o.div_start = 1'b1;
          cnt_d = CntW'(FracBits);
          state_d = SFinLog;
        end else if (sts_i.last) begin
          cmd_o.finish = 1'b1;
          out_valid_d = 1'b1;
          state_d = SOut;
        end else begin
          state_d = SIdle;
        end
      end
      SFinLog: begin
        cmd_o.log_step = 1'b1;
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          cnt_d = CntW'(DivSteps);
          state_d = SDiv;
        end
      end
      SDiv: begin
        cmd_o.div_step = 1'b1;
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) state_d = SOut;
      end
      SOut: begin
        if (!out_valid_q) begin
          cmd_o.finish = 1'b1;
          out_valid_d = 1'b1;
        end else if (out_ready_i) begin
          out_valid_d = 1'b0;
          cmd_o.clear = 1'b1;
          state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      cnt_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == SIdle);
  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.take |-> state_q == SIdle) else $error("take outside idle");
  a_out_only_in_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> state_q == SOut) else $error("result outside output state");
  a_clear_after_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_ready_i) |=> state_q == SIdle && !out_valid_q)
    else $error("no return to idle");
`endif

endmodule

// ----- hdl/sse_dp.sv -----
// Datapath: run counting, iterative log2, c*log2(c) sum, restoring divider.
// Depends on sse_pkg.
module sse_dp #(
  parameter int unsigned MaxItems = 65536,
  parameter int unsigned FracBits = 16,
  parameter int unsigned SampleW  = 32,
  parameter int unsigned CntW     = 17
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [31:0]                    sample_value_i,
  input  logic                           last_item_i,
  input  sse_pkg::cmd_t                  cmd_i,
  output sse_pkg::sts_t                  sts_o,
  output logic [sse_pkg::OutWidth-1:0]   entropy_bits_o,
  output logic [sse_pkg::StWidth-1:0]    status_o
);

  localparam int unsigned SW  = sse_pkg::SumWidth;
  localparam int unsigned LogW = 5 + FracBits;
  localparam int unsigned KeyW = (SampleW > 32) ? 32 : SampleW;
  localparam int unsigned ProdW = CntW + LogW;
  localparam logic [SW-1:0] SumMax = '1;

  logic [KeyW-1:0] prev_q;
  logic have_q;
  logic [CntW-1:0] run_q, cnt_q, closed_q;
  logic [SW-1:0] sum_q;
  logic [sse_pkg::StWidth-1:0] err_q;
  logic last_q, close_q;

  // Sign bit flipped so unsigned compare matches signed order.
  logic [KeyW-1:0] key;
  assign key = sample_value_i[KeyW-1:0] ^ {1'b1, {(KeyW-1){1'b0}}};

  // log2 unit
  logic [31:0] m_q;
  logic [LogW-1:0] lg_q;
  logic [CntW-1:0] lx;
  logic [4:0] e;
  logic [63:0] sq;
  logic [32:0] mn;
  logic [ProdW-1:0] prod;
  logic [SW:0] sum_add;

  // divider
  logic [SW-1:0] dq_q;
  logic [CntW:0] rem_q;
  logic [CntW:0] rtry;

  // A run ended by the taken sample sits in closed_q; at the final mark the
  // open run is still in run_q.
  assign lx = cmd_i.log_sel_n ? cnt_q : (close_q ? closed_q : run_q);

  always_comb begin
    e = '0;
    for (int i = 0; i < CntW; i++) if (lx[i]) e = 5'(i);
  end

  assign sq = 64'(m_q) * 64'(m_q);
  assign mn = sq[63:31];
  assign prod = ProdW'(closed_q) * ProdW'(lg_q);
  assign sum_add = {1'b0, sum_q} + (SW+1)'(prod);
  assign rtry = {rem_q[CntW-1:0], dq_q[SW-1]} - {1'b0, cnt_q};

  logic [LogW:0] diff;
  logic q_big;
  assign diff = {1'b0, lg_q} - (LogW+1)'(dq_q);
  assign q_big = |dq_q[SW-1:LogW];

  always_ff @(posedge clk_i) begin
    if (cmd_i.log_start) begin
      m_q <= 32'(lx) << (5'd31 - e);
      lg_q <= LogW'(e);
    end else if (cmd_i.log_step) begin
      if (mn[32]) begin
        m_q <= mn[32:1];
        lg_q <= {lg_q[LogW-2:0], 1'b1};
      end else begin
        m_q <= mn[31:0];
        lg_q <= {lg_q[LogW-2:0], 1'b0};
      end
    end
    // Load the saturated sum, then shift out one quotient bit per step.
    if (cmd_i.div_start) begin
      rem_q <= '0;
      dq_q <= sum_add[SW] ? SumMax : sum_add[SW-1:0];
    end else if (cmd_i.div_step) begin
      if (!rtry[CntW]) begin
        rem_q <= rtry;
        dq_q <= {dq_q[SW-2:0], 1'b1};
      end else begin
        rem_q <= {rem_q[CntW-1:0], dq_q[SW-1]};
        dq_q <= {dq_q[SW-2:0], 1'b0};
      end
    end
    if (cmd_i.finish) begin
      status_o <= err_q;
      if (err_q != sse_pkg::StOk || cnt_q == '0 || q_big || diff[LogW]) begin
        entropy_bits_o <= '0;
      end else if (|(diff >> sse_pkg::OutWidth)) begin
        entropy_bits_o <= '1;
      end else begin
        entropy_bits_o <= sse_pkg::OutWidth'(diff);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0; have_q <= 1'b0; run_q <= '0; cnt_q <= '0; closed_q <= '0;
      sum_q <= '0; err_q <= sse_pkg::StOk; last_q <= 1'b0; close_q <= 1'b0;
    end else if (cmd_i.clear) begin
      prev_q <= '0; have_q <= 1'b0; run_q <= '0; cnt_q <= '0; closed_q <= '0;
      sum_q <= '0; err_q <= sse_pkg::StOk; last_q <= 1'b0; close_q <= 1'b0;
    end else begin
      if (cmd_i.take) begin
        logic [sse_pkg::StWidth-1:0] en;
        en = err_q;
        last_q <= last_item_i;
        close_q <= 1'b0;
        if (cnt_q >= CntW'(MaxItems)) begin
          if (en == sse_pkg::StOk) en = sse_pkg::StTooMany;
        end else begin
          cnt_q <= cnt_q + 1'b1;
        end
        if (en == sse_pkg::StOk) begin
          if (!have_q) begin
            prev_q <= key; have_q <= 1'b1; run_q <= CntW'(1);
          end else if (key < prev_q) begin
            en = sse_pkg::StNotSorted;
          end else if (key == prev_q) begin
            run_q <= run_q + 1'b1;
          end else begin
            closed_q <= run_q; close_q <= 1'b1;
            prev_q <= key; run_q <= CntW'(1);
          end
        end
        err_q <= en;
      end else if (cmd_i.log_start && !cmd_i.log_sel_n) begin
        // final close of open run
        if (!close_q) begin
          closed_q <= run_q;
          run_q <= '0;
        end
        close_q <= 1'b0;
      end
      if (cmd_i.acc_run) sum_q <= sum_add[SW] ? SumMax : sum_add[SW-1:0];
    end
  end

  assign sts_o.close_run = close_q;
  assign sts_o.last      = last_q;
  assign sts_o.final_ok  = (err_q == sse_pkg::StOk) && (cnt_q != '0);
  assign sts_o.run_nz    = (run_q != '0);

endmodule

// ----- hdl/sorted_sample_entropy.sv -----
// Top level of the sorted-sample entropy block.
// Depends on sse_pkg, sse_ctrl and sse_dp.
//
// Takes one sample per request in ascending order; the sample marked last
// returns entropy log2(N) - S/N in bits (unsigned, FRACTION_BITS fraction
// bits) with a status. A sample that ends a run also passes through the
// sequential square-and-compare log2 unit. Without an error, the final
// sample adds a second log2 pass and a restoring divide of one quotient
// bit per cycle.
module sorted_sample_entropy #(
  parameter int unsigned MAX_ITEMS     = 65536,
  parameter int unsigned FRACTION_BITS = 16,
  parameter int unsigned SAMPLE_WIDTH  = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] sample_value_i,
  input  logic        last_item_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [20:0] entropy_bits_o,
  output logic [1:0]  status_o
);

  localparam int unsigned CntW = $clog2(MAX_ITEMS + 1);

  sse_pkg::cmd_t cmd;
  sse_pkg::sts_t sts;

  sse_ctrl #(.FracBits(FRACTION_BITS), .DivSteps(sse_pkg::SumWidth)) u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .cmd_o(cmd), .sts_i(sts)
  );

  sse_dp #(.MaxItems(MAX_ITEMS), .FracBits(FRACTION_BITS),
           .SampleW(SAMPLE_WIDTH), .CntW(CntW)) u_dp (
    .clk_i, .rst_ni, .sample_value_i, .last_item_i, .cmd_i(cmd), .sts_o(sts),
    .entropy_bits_o, .status_o
  );

endmodule

// ----- dv/sse_checker.sv -----
// Checker for the sorted-sample entropy block: watches the request and result channels,
// predicts the entropy result of each data set and compares. Uses sse_pkg.
`timescale 1ns / 100ps
module sse_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [31:0] sample_value_i,
  input  logic        last_item_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [20:0] entropy_bits_i,
  input  logic [1:0]  status_i,
  output int          fail_count_o,
  output int          pending_o
);

  localparam longint unsigned MaxSamples = 65536;
  localparam longint unsigned SumMax = (64'd1 << sse_pkg::SumWidth) - 1;
  localparam longint unsigned EntMax = (64'd1 << sse_pkg::OutWidth) - 1;

  typedef struct {
    logic [sse_pkg::OutWidth-1:0] entropy;
    logic [sse_pkg::StWidth-1:0]  status;
  } entropy_res_t;

  entropy_res_t entropy_q[$];

  longint unsigned prev_key, run_len, n_samples, log_sum;
  bit              have_prev;
  logic [sse_pkg::StWidth-1:0] err_st = sse_pkg::StOk;

  function automatic longint unsigned log2_fixed(longint unsigned x);
    longint unsigned e, m, res;
    e = 0;
    if (x == 0) return 0;
    while (e < 31 && (x >> (e + 1)) != 0) e++;
    m = x << (31 - e);
    res = e;
    for (int k = 0; k < 16; k++) begin
      m = (m * m) >> 31;
      res = res << 1;
      if (m >= (64'd1 << 32)) begin
        res |= 1;
        m = m >> 1;
      end
    end
    return res;
  endfunction

  task automatic add_run();
    longint unsigned add;
    if (run_len == 0) return;
    add = run_len * log2_fixed(run_len);
    if (add > SumMax - log_sum) log_sum = SumMax;
    else log_sum += add;
  endtask

  task automatic clear_set();
    prev_key = 0; have_prev = 0; run_len = 0;
    n_samples = 0; log_sum = 0; err_st = sse_pkg::StOk;
  endtask

  task automatic take_sample(logic [31:0] v, logic last);
    longint unsigned key, ln, q, ent;
    entropy_res_t r;
    key = {32'd0, v ^ 32'h8000_0000};
    ent = 0;
    if (n_samples >= MaxSamples) begin
      if (err_st == sse_pkg::StOk) err_st = sse_pkg::StTooMany;
    end else n_samples++;
    if (err_st == sse_pkg::StOk) begin
      if (!have_prev) begin
        prev_key = key; have_prev = 1; run_len = 1;
      end else if (key < prev_key) err_st = sse_pkg::StNotSorted;
      else if (key == prev_key) run_len++;
      else begin
        add_run();
        prev_key = key; run_len = 1;
      end
    end
    if (!last) return;
    if (err_st == sse_pkg::StOk && n_samples != 0) begin
      add_run();
      ln = log2_fixed(n_samples);
      q = log_sum / n_samples;
      ent = (ln > q) ? ln - q : 0;
      if (ent > EntMax) ent = EntMax;
    end
    r.entropy = ent[sse_pkg::OutWidth-1:0];
    r.status = err_st;
    entropy_q = {entropy_q, r};
    clear_set();
  endtask

  always @(posedge clk_i) begin
    entropy_res_t exp_r;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) take_sample(sample_value_i, last_item_i);
      if (out_valid_i && out_ready_i) begin
        if (entropy_q.size() == 0) begin
          $error("unexpected result entropy_bits=%0d status=%0d", entropy_bits_i, status_i);
          fail_count_o++;
        end else begin
          exp_r = entropy_q.pop_front();
          if (entropy_bits_i !== exp_r.entropy) begin
            $error("entropy_bits expected %0d actual %0d", exp_r.entropy, entropy_bits_i);
            fail_count_o++;
          end
          if (status_i !== exp_r.status) begin
            $error("status expected %0d actual %0d", exp_r.status, status_i);
            fail_count_o++;
          end
        end
      end
    end
    pending_o = entropy_q.size();
  end
endmodule

// ----- dv/tb_sorted_sample_entropy.sv -----
// Testbench top for sorted_sample_entropy: drives sample requests and the
// result ready, and gives the verdict. Depends on sorted_sample_entropy, sse_checker and sse_pkg.
`timescale 1ns / 100ps
module tb_sorted_sample_entropy;
  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        in_valid_i = 0;
  logic        in_ready_o;
  logic [31:0] sample_value_i = '0;
  logic        last_item_i = 0;
  logic        out_valid_o;
  logic        out_ready_i = 0;
  logic [20:0] entropy_bits_o;
  logic [1:0]  status_o;
  int          fail_count, pending;
  int          cycle_count = 0;
  bit          calm = 0;    // no idling while set

  localparam int CycleLimit = 1_500_000;

  always begin
    #6 clk_i = 1;
    #6 clk_i = 0;
  end

  sorted_sample_entropy dut (.*);

  sse_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .sample_value_i, .last_item_i,
    .out_valid_i(out_valid_o), .out_ready_i, .entropy_bits_i(entropy_bits_o),
    .status_i(status_o), .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_ready_i <= calm || ($urandom_range(99) >= 24);
  end

  // Hold the request until accepted, with a random idle gap before it.
  task automatic send_sample(logic [31:0] v, logic last);
    while (!calm && $urandom_range(99) < 24) begin
      in_valid_i <= 0;
      @(posedge clk_i);
    end
    in_valid_i <= 1;
    sample_value_i <= v;
    last_item_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // One set: n samples from base, stepping down on about err_pct percent of steps, with runs of random length.
  task automatic send_set(int n, logic [31:0] base, int dup_pct, int err_pct);
    logic [31:0] v;
    v = base;
    for (int i = 0; i < n; i++) begin
      if (i != 0) begin
        if ($urandom_range(99) < err_pct) v = v - $urandom_range(1, 1000);
        else if ($urandom_range(99) >= dup_pct) v = v + (($urandom_range(3) == 0) ?
            $urandom : $urandom_range(1, 50));
      end
      send_sample(v, i == n - 1);
    end
  endtask

  int sent;
  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // directed: single sample, extremes, single run, descending, wrap order
    send_sample(32'h8000_0000, 1);
    send_sample(32'h7fff_ffff, 1);
    send_sample(32'h8000_0000, 0);
    send_sample(32'h7fff_ffff, 1);
    repeat (3) send_sample(32'd5, 0);
    send_sample(32'd5, 1);
    send_sample(32'd10, 0);
    send_sample(32'd3, 0);
    send_sample(32'd20, 1);
    send_sample(32'hffff_ffff, 0);
    send_sample(32'd0, 0);
    send_sample(32'd0, 0);
    send_sample(32'h5555_5555, 0);
    send_sample(32'haaaa_aaaa, 1);
    send_set(8, 32'd0, 0, 0);
    sent = 0;
    while (sent < 425) begin
      int n;
      n = $urandom_range(1, 20);
      if (sent > 150 && sent < 250) calm = 1;
      else calm = 0;
      send_set(n, $urandom, $urandom_range(80), ($urandom_range(9) == 0) ? 10 : 0);
      sent += n;
    end
    in_valid_i <= 0;
    calm = 0;
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (fail_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule

// ----- files.f -----
hdl/sse_pkg.sv
hdl/sse_ctrl.sv
hdl/sse_dp.sv
hdl/sorted_sample_entropy.sv
dv/sse_checker.sv
dv/tb_sorted_sample_entropy.sv
